// File: rtl/aiosc_pkg.sv
package aiosc_pkg;

  // bus command carried in tuser
  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_PWR_FAIL = 2'd2,
    CMD_NOP      = 2'd3
  } aiosc_cmd_e;

  // register select codes, address bits 27:16
  localparam int unsigned SelW = 12;
  localparam logic [SelW-1:0] SEL_CONFIG = 12'h180;
  localparam logic [SelW-1:0] SEL_AUX1   = 12'h190;
  localparam logic [SelW-1:0] SEL_AUX2   = 12'h191;
  localparam logic [SelW-1:0] SEL_DIAG   = 12'h1a0;
  localparam logic [SelW-1:0] SEL_MODEM  = 12'h1b0;
  localparam logic [SelW-1:0] SEL_SYSCTL = 12'h1f0;
  localparam logic [SelW-1:0] SEL_PWRMGT = 12'ha00;

  // status value after a system reset request
  localparam logic [1:0] SYSCTL_RESET_DONE = 2'd2;

  // one request into the register file
  typedef struct packed {
    aiosc_cmd_e  cmd;
    logic [27:0] address;
    logic [7:0]  write_data;
    logic        pwr_fail_line;
  } aiosc_req_t;

  // one response out of the register file
  typedef struct packed {
    logic       halt_request;
    logic       reset_request;
    logic       shutdown_request;
    logic       irq_level;
    logic [7:0] read_data;
  } aiosc_rsp_t;

endpackage

// File: rtl/aiosc_regfile.sv
module aiosc_regfile
  import aiosc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  aiosc_req_t req_i,
  output aiosc_rsp_t rsp_o
);

  logic [7:0] config_q, config_d;
  logic [7:0] aux1_q, aux1_d;
  logic [2:0] aux2_q, aux2_d;
  logic [7:0] diag_q, diag_d;
  logic [7:0] modem_q, modem_d;
  logic [1:0] sysctl_q, sysctl_d;
  logic [SelW-1:0] sel;

  assign sel = req_i.address[27:16];

  // decode the request, next register values and response
  always_comb begin
    config_d = config_q;
    aux1_d   = aux1_q;
    aux2_d   = aux2_q;
    diag_d   = diag_q;
    modem_d  = modem_q;
    sysctl_d = sysctl_q;
    rsp_o    = '0;
    unique case (req_i.cmd)
      CMD_READ: begin
        unique case (sel)
          SEL_CONFIG: rsp_o.read_data = config_q;
          SEL_AUX1:   rsp_o.read_data = aux1_q;
          SEL_AUX2:   rsp_o.read_data = {5'd0, aux2_q};
          SEL_DIAG:   rsp_o.read_data = diag_q;
          SEL_MODEM:  rsp_o.read_data = modem_q;
          SEL_SYSCTL: rsp_o.read_data = {6'd0, sysctl_q};
          default:    rsp_o.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (sel)
          SEL_CONFIG: config_d = req_i.write_data;
          SEL_AUX1:   aux1_d   = req_i.write_data;
          SEL_AUX2: begin
            // bit 1 clears the pending power-fail bit and is never stored
            if (req_i.write_data[1]) begin
              aux2_d = {2'b00, req_i.write_data[0]};
            end else begin
              aux2_d = {aux2_q[2], 1'b0, req_i.write_data[0]};
            end
            rsp_o.shutdown_request = req_i.write_data[0];
          end
          SEL_DIAG:   diag_d  = req_i.write_data;
          SEL_MODEM:  modem_d = req_i.write_data;
          SEL_SYSCTL: begin
            if (req_i.write_data[0]) begin
              sysctl_d            = SYSCTL_RESET_DONE;
              rsp_o.reset_request = 1'b1;
            end
          end
          SEL_PWRMGT: rsp_o.halt_request = 1'b1;
          default: ;
        endcase
      end
      CMD_PWR_FAIL: begin
        aux2_d[2] = req_i.pwr_fail_line & config_q[3];
      end
      CMD_NOP: ;
    endcase
    // interrupt level after this request
    rsp_o.irq_level = aux2_d[2] & config_d[3];
  end

  // register state, updated only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      config_q <= '0;
      aux1_q   <= '0;
      aux2_q   <= '0;
      diag_q   <= '0;
      modem_q  <= '0;
      sysctl_q <= '0;
    end else if (req_valid_i) begin
      config_q <= config_d;
      aux1_q   <= aux1_d;
      aux2_q   <= aux2_d;
      diag_q   <= diag_d;
      modem_q  <= modem_d;
      sysctl_q <= sysctl_d;
    end
  end

endmodule

// File: rtl/aux_io_system_control_regs_unit.sv
// Auxiliary I/O and system control byte register block.
// Requests enter on the s_axis channel: tuser holds the command (read,
// write, power-fail event, no-op), tdata the address, write byte and
// power-fail level. Register select is address bits 27:16.
// Every request yields exactly one response on the m_axis channel with
// the read byte, the interrupt level after the request and three
// one-response pulses: shutdown, reset and halt requests.
// A request's response is registered and shown in the cycle after the
// request is accepted. The block takes one request per cycle while the
// receiver does not stall; the register file is updated and the response
// captured in the same cycle, so the response register is the only stage.
// A request is taken whenever the response register is empty or being
// drained, so a stalled receiver holds the response stable and stops new
// requests only while it stays stalled.
// Reset clears the register file and drops the response valid, but not the
// response payload register; the block is ready in the first cycle after reset.
module aux_io_system_control_regs_unit
  import aiosc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [27:0] address, [35:28] write_data, [36] pwr_fail_line, [39:37] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [8] irq_level, [9] shutdown_request,
  // [10] reset_request, [11] halt_request, [15:12] zero
  output logic [15:0] m_axis_tdata_o
);

  aiosc_req_t req;
  aiosc_rsp_t rsp;
  aiosc_rsp_t rsp_q;
  logic       valid_q, valid_d;
  logic       accept;

  // unpack the request
  assign req.cmd           = aiosc_cmd_e'(s_axis_tuser_i);
  assign req.address       = s_axis_tdata_i[27:0];
  assign req.write_data    = s_axis_tdata_i[35:28];
  assign req.pwr_fail_line = s_axis_tdata_i[36];

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  aiosc_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  // response valid
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {4'd0, rsp_q};

endmodule

// File: rtl/aiosc_checker.sv
module aiosc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // stalled response stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled response changed");

  // every accepted request shows a response next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("response missing after request");

  // an empty response register never blocks requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request blocked while output empty");

  // at most one request pulse per response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(m_axis_tdata_o[11:9]))
    else $error("more than one request pulse");

  // a read never raises a request pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[7:0] != 8'd0) |-> (m_axis_tdata_o[11:9] == 3'd0))
    else $error("read with request pulse");

endmodule

bind aux_io_system_control_regs_unit aiosc_checker u_aiosc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: tb/aux_io_system_control_regs_unit_tb.sv
module aux_io_system_control_regs_unit_tb
  import aiosc_pkg::*;
;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // [27:0] address, [35:28] write_data, [36] pwr_fail_line, [39:37] zero
  logic [39:0] s_axis_tdata_i;
  // [1:0] command
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [7:0] read_data, [8] irq_level, [9] shutdown_request,
  // [10] reset_request, [11] halt_request, [15:12] zero
  logic [15:0] m_axis_tdata_o;

  aux_io_system_control_regs_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // directed request with an optional hand-written response
  typedef struct {
    aiosc_req_t  req;
    bit          has_rsp;
    logic [15:0] rsp;
  } boot_row_t;

  // shadow copy of the register file
  logic [7:0] cfg_q   = '0;
  logic [7:0] aux1_q  = '0;
  logic [2:0] aux2_q  = '0;
  logic [7:0] diag_q  = '0;
  logic [7:0] modem_q = '0;
  logic [1:0] sysst_q = '0;

  logic [15:0] pending_rsp_q[$];
  logic [15:0] rsp_want;
  boot_row_t   boot_rows[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_pending = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // apply one request to the shadow registers, return the response word
  function automatic logic [15:0] regfile_apply(input aiosc_req_t req);
    logic [11:0] sel;
    logic [7:0]  rd;
    logic [2:0]  nv;
    logic        shut;
    logic        rreq;
    logic        halt;
    sel  = req.address[27:16];
    rd   = '0;
    shut = 1'b0;
    rreq = 1'b0;
    halt = 1'b0;
    case (req.cmd)
      CMD_READ: begin
        case (sel)
          SEL_CONFIG: rd = cfg_q;
          SEL_AUX1:   rd = aux1_q;
          SEL_AUX2:   rd = {5'd0, aux2_q};
          SEL_DIAG:   rd = diag_q;
          SEL_MODEM:  rd = modem_q;
          SEL_SYSCTL: rd = {6'd0, sysst_q};
          default:    rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (sel)
          SEL_CONFIG: cfg_q = req.write_data;
          SEL_AUX1:   aux1_q = req.write_data;
          SEL_AUX2: begin
            // setting bit 1 drops the held power-fail bit as well
            nv = {aux2_q[2], req.write_data[1:0]};
            if (nv[1]) nv = {2'b00, nv[0]};
            aux2_q = nv;
            shut = nv[0];
          end
          SEL_DIAG:   diag_q = req.write_data;
          SEL_MODEM:  modem_q = req.write_data;
          SEL_SYSCTL: begin
            if (req.write_data[0]) begin
              sysst_q = SYSCTL_RESET_DONE;
              rreq = 1'b1;
            end
          end
          SEL_PWRMGT: halt = 1'b1;
          default: ;
        endcase
      end
      CMD_PWR_FAIL: aux2_q[2] = req.pwr_fail_line & cfg_q[3];
      default: ;
    endcase
    return {4'd0, halt, rreq, shut, aux2_q[2] & cfg_q[3], rd};
  endfunction

  // random request, biased toward mapped registers
  function automatic aiosc_req_t random_request();
    aiosc_req_t  r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) r.cmd = CMD_READ;
    else if (roll < 80) r.cmd = CMD_WRITE;
    else if (roll < 95) r.cmd = CMD_PWR_FAIL;
    else r.cmd = CMD_NOP;
    r.address = 28'($urandom);
    case ($urandom_range(8))
      0: r.address[27:16] = SEL_CONFIG;
      1: r.address[27:16] = SEL_AUX1;
      2: r.address[27:16] = SEL_AUX2;
      3: r.address[27:16] = SEL_DIAG;
      4: r.address[27:16] = SEL_MODEM;
      5: r.address[27:16] = SEL_SYSCTL;
      6: r.address[27:16] = SEL_PWRMGT;
      default: ;
    endcase
    r.write_data    = 8'($urandom);
    r.pwr_fail_line = 1'($urandom);
    return r;
  endfunction

  // offer one request, wait for the handshake, record its response
  task automatic offer(input aiosc_req_t req, input bit has_rsp, input logic [15:0] rsp);
    logic [15:0] model_rsp;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i  = 40'({$urandom, $urandom});
      s_axis_tuser_i  = 2'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {3'b000, req.pwr_fail_line, req.write_data, req.address};
    s_axis_tuser_i  = req.cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    model_rsp = regfile_apply(req);
    pending_rsp_q.push_back(has_rsp ? rsp : model_rsp);
  endtask

  task automatic report_mismatch(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    errors++;
  endtask

  // response receiver with random stalls and one long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 64;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: response with none pending, expected nothing, got %h",
                 $time, m_axis_tdata_o);
        errors++;
      end else begin
        rsp_want = pending_rsp_q.pop_front();
        if (m_axis_tdata_o[7:0] !== rsp_want[7:0])
          report_mismatch("read_data", rsp_want[7:0], m_axis_tdata_o[7:0]);
        if (m_axis_tdata_o[8] !== rsp_want[8])
          report_mismatch("irq_level", 8'(rsp_want[8]), 8'(m_axis_tdata_o[8]));
        if (m_axis_tdata_o[9] !== rsp_want[9])
          report_mismatch("shutdown_request", 8'(rsp_want[9]), 8'(m_axis_tdata_o[9]));
        if (m_axis_tdata_o[10] !== rsp_want[10])
          report_mismatch("reset_request", 8'(rsp_want[10]), 8'(m_axis_tdata_o[10]));
        if (m_axis_tdata_o[11] !== rsp_want[11])
          report_mismatch("halt_request", 8'(rsp_want[11]), 8'(m_axis_tdata_o[11]));
        if (m_axis_tdata_o[15:12] !== rsp_want[15:12])
          report_mismatch("pad", 8'(rsp_want[15:12]), 8'(m_axis_tdata_o[15:12]));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned idle_pct[4];
    int unsigned stall_pct[4];
    idle_pct  = '{0, 50, 0, 27};
    stall_pct = '{0, 0, 50, 27};
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_NOP;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: reset values, extremes, aux2 and power-fail corners
    boot_rows.push_back('{'{CMD_READ, 28'h1800000, 8'h00, 1'b0}, 1'b1, 16'h0000});
    boot_rows.push_back('{'{CMD_READ, 28'hfffffff, 8'hff, 1'b1}, 1'b1, 16'h0000});
    boot_rows.push_back('{'{CMD_READ, 28'h1f0abcd, 8'h00, 1'b0}, 1'b1, 16'h0000});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1800000, 8'hff, 1'b0}, 1'b1, 16'h0000});
    boot_rows.push_back('{'{CMD_READ, 28'h180ffff, 8'h00, 1'b0}, 1'b1, 16'h00ff});
    boot_rows.push_back('{'{CMD_PWR_FAIL, 28'h0000000, 8'h00, 1'b1}, 1'b1, 16'h0100});
    boot_rows.push_back('{'{CMD_READ, 28'h1910000, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1910000, 8'h01, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_READ, 28'h1910000, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1910000, 8'h02, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_PWR_FAIL, 28'hfffffff, 8'hff, 1'b1}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h191ffff, 8'hff, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_PWR_FAIL, 28'h0000000, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1f00000, 8'hfe, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1f00000, 8'h01, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_READ, 28'h1f00000, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'ha00ffff, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_READ, 28'ha000000, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1900000, 8'ha5, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1a00000, 8'h5a, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1b00000, 8'hff, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'hfffffff, 8'hff, 1'b1}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_NOP, 28'hfffffff, 8'hff, 1'b1}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_WRITE, 28'h1800000, 8'h00, 1'b0}, 1'b0, '0});
    boot_rows.push_back('{'{CMD_PWR_FAIL, 28'h0000000, 8'h00, 1'b1}, 1'b0, '0});
    foreach (boot_rows[i]) offer(boot_rows[i].req, boot_rows[i].has_rsp, boot_rows[i].rsp);

    // random phases with different idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      if (p == 0) hold_pending = 1'b1;
      repeat (475) offer(random_request(), 1'b0, '0);
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    recv_stall_pct  = 0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (errors == 0 && pending_rsp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/aiosc_pkg.sv
rtl/aiosc_regfile.sv
rtl/aux_io_system_control_regs_unit.sv
rtl/aiosc_checker.sv
tb/aux_io_system_control_regs_unit_tb.sv
